>>> sv/gwd_pkg.sv
package gwd_pkg;

  localparam int VSUM_W = 56;
  localparam int WSUM_W = 40;
  localparam int TERM_W = 48;
  localparam int SCALE_W = 24;
  localparam int DIV_STEPS = 72;
  localparam int SQRT_STEPS = 24;
  localparam int ITEM_W = 72;
  localparam int GSUM_W = VSUM_W + WSUM_W;
  localparam int PADDR_W = 3;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  localparam logic [PADDR_W-1:0] ADDR_MODE = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_GROUP_COUNT = 3'd4;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_SQRT_W = 2'd2;

  localparam logic [1:0] MODE_RESET = MODE_PLAIN;
  localparam logic [6:0] GROUP_COUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_GROUP = 2'd1,
    ST_ZERO_WSUM = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_LOAD,
    S_DRAIN,
    S_RD_ITEM,
    S_RD_GRP,
    S_CHECK,
    S_DIV,
    S_MUL_LO,
    S_MUL_HI,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic                     start;
    logic signed [VSUM_W-1:0] vsum;
    logic [WSUM_W-1:0]        wsum;
    logic [31:0]              weight;
  } arith_req_t;

  typedef struct packed {
    logic                done;
    logic [63:0]         mean;
    logic [SCALE_W-1:0]  scale;
  } arith_rsp_t;

endpackage

>>> sv/gwd_if.sv
interface gwd_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         group;
  logic signed [31:0] sample;
  logic [31:0]        item_weight;
  logic               last;

  modport source (output valid, group, sample, item_weight, last, input ready);
  modport sink (input valid, group, sample, item_weight, last, output ready);
endinterface

interface gwd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic [5:0]         position;
  logic [1:0]         status;
  logic               dropped;
  logic               end_of_run;

  modport source (output valid, out_value, position, status, dropped, end_of_run,
                  input ready);
  modport sink (input valid, out_value, position, status, dropped, end_of_run,
                output ready);
endinterface

>>> sv/grouped_weighted_demean.sv
// Within-group demeaning over a batch of up to MAX_ITEMS items. Items load at one request
// per cycle; each is stored and, if its group is in range, added to its group sums by a
// read-modify-write of the group memory with the previous write forwarded. A drain state
// follows the last request, then one result per stored item comes out in load order. A
// result whose group is out of range or has zero weight sum passes the item read, group
// read, check and emit states; others also wait on the bit-serial mean divider (72 steps,
// one per cycle) and, in mode 2, the multiply states, plus any output stall. No input is
// taken while results flow. Group sums and batch state clear at once after the last result.
module grouped_weighted_demean #(
  parameter int MAX_ITEMS = 64,
  parameter int MAX_GROUPS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gwd_in_if.sink                        in_i,
  gwd_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gwd_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import gwd_pkg::*;

  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  state_e state_q, state_d;

  logic [1:0]  mode_q;
  logic [6:0]  gcount_q;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] k_q;
  logic [MAX_GROUPS-1:0] gvalid_q;

  // control
  logic in_ready, in_acc, store, grp_ok, emit_go, last_res, arith_start, div_go;

  // load path
  logic [31:0]          we_sel;
  logic signed [64:0]   prod;
  logic                 s1_valid_q;
  logic [GIW-1:0]       s1_addr_q;
  logic signed [TERM_W-1:0] s1_term_q;
  logic [31:0]          s1_we_q;
  logic                 wr_valid_q;
  logic [GIW-1:0]       wr_addr_q;
  logic [GSUM_W-1:0]    wr_data_q;
  logic [GSUM_W-1:0]    gbase;
  logic signed [VSUM_W-1:0] sum_v;
  logic [WSUM_W-1:0]    sum_w;
  logic [GSUM_W-1:0]    gwdata;

  // memories
  logic [ITEM_W-1:0] item_wdata, item_rdata;
  logic [IW-1:0]     item_waddr, item_raddr;
  logic [GSUM_W-1:0] grp_rdata;
  logic [GIW-1:0]    grp_raddr;
  logic [7:0]        g_sel;

  // output path
  logic signed [31:0] val_q;
  logic [31:0]        wgt_q;
  logic [7:0]         grp_q;
  status_e            status_q;
  logic [GIW-1:0]     gidx;
  logic [GSUM_W-1:0]  gsum_rd;
  logic [63:0]        d_q;
  logic [55:0]        prod_q;
  logic [63:0]        r_q;
  logic [55:0]        mul_p;
  logic [63:0]        res_full;
  logic               sat;
  logic [31:0]        res_clamp;
  arith_req_t         areq;
  arith_rsp_t         arsp;

  logic               ov_q;
  logic signed [31:0] ov_value_q;
  logic [5:0]         ov_pos_q;
  logic [1:0]         ov_status_q;
  logic               ov_drop_q;
  logic               ov_end_q;

  // configuration
  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      ADDR_MODE:        prdata = {30'b0, mode_q};
      ADDR_GROUP_COUNT: prdata = {25'b0, gcount_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
      gcount_q <= GROUP_COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr == ADDR_MODE) begin
        mode_q <= pwdata[1:0];
      end else if (paddr == ADDR_GROUP_COUNT) begin
        gcount_q <= pwdata[6:0];
      end
    end
  end

  assign div_go = (status_q == ST_OK) && (gsum_rd[WSUM_W-1:0] != '0);

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    emit_go = 1'b0;
    arith_start = 1'b0;
    case (state_q)
      S_LOAD:  in_ready = 1'b1;
      S_CHECK: arith_start = div_go;
      S_EMIT:  emit_go = !ov_q || out_o.ready;
      default: ;
    endcase
  end

  assign in_acc = in_i.valid && in_ready;
  assign store = in_acc && (cnt_q < CW'(MAX_ITEMS));
  assign grp_ok = (in_i.group != 8'd0) && (in_i.group <= {1'b0, gcount_q})
                  && (in_i.group <= 8'(MAX_GROUPS));
  assign last_res = ({1'b0, k_q} + (IW+1)'(1)) == (IW+1)'(cnt_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:    if (in_acc && in_i.last) state_d = S_DRAIN;
      S_DRAIN:   state_d = S_RD_ITEM;
      S_RD_ITEM: state_d = S_RD_GRP;
      S_RD_GRP:  state_d = S_CHECK;
      S_CHECK:   state_d = div_go ? S_DIV : S_EMIT;
      S_DIV:     if (arsp.done) state_d = (mode_q == MODE_SQRT_W) ? S_MUL_LO : S_EMIT;
      S_MUL_LO:  state_d = S_MUL_HI;
      S_MUL_HI:  state_d = S_EMIT;
      S_EMIT:    if (emit_go) state_d = last_res ? S_LOAD : S_RD_ITEM;
      default:   state_d = S_LOAD;
    endcase
  end

  // batch counters
  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (store) begin
      cnt_d = cnt_q + CW'(1);
    end else if (in_acc) begin
      ovf_d = 1'b1;
    end
    if (emit_go && last_res) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      k_q <= '0;
      gvalid_q <= '0;
      s1_valid_q <= 1'b0;
      wr_valid_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
      s1_valid_q <= store && grp_ok;
      wr_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        gvalid_q[s1_addr_q] <= 1'b1;
      end
      if (emit_go) begin
        k_q <= last_res ? '0 : k_q + IW'(1);
        if (last_res) begin
          gvalid_q <= '0;
        end
      end
      if (emit_go) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // load: product, then read-modify-write of the group sums
  assign we_sel = (mode_q == MODE_PLAIN) ? ONE_Q16 : in_i.item_weight;
  assign prod = $signed({1'b0, we_sel}) * in_i.sample;

  always_ff @(posedge clk_i) begin
    s1_addr_q <= in_i.group[GIW-1:0] - GIW'(1);
    s1_term_q <= prod[63:16];
    s1_we_q <= we_sel;
    wr_addr_q <= s1_addr_q;
    wr_data_q <= gwdata;
  end

  always_comb begin
    if (wr_valid_q && wr_addr_q == s1_addr_q) begin
      gbase = wr_data_q;
    end else if (gvalid_q[s1_addr_q]) begin
      gbase = grp_rdata;
    end else begin
      gbase = '0;
    end
  end

  assign sum_v = $signed(gbase[GSUM_W-1:WSUM_W])
                 + {{(VSUM_W-TERM_W){s1_term_q[TERM_W-1]}}, s1_term_q};
  assign sum_w = gbase[WSUM_W-1:0] + WSUM_W'(s1_we_q);
  assign gwdata = {sum_v, sum_w};

  // memories
  assign item_waddr = cnt_q[IW-1:0];
  assign item_wdata = {(grp_ok ? in_i.group : 8'd0), in_i.item_weight, in_i.sample};
  assign item_raddr = k_q;
  assign g_sel = (state_q == S_LOAD) ? in_i.group : item_rdata[ITEM_W-1:64];
  assign grp_raddr = g_sel[GIW-1:0] - GIW'(1);

  gwd_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS)) u_item_ram (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (item_waddr),
    .wdata_i (item_wdata),
    .raddr_i (item_raddr),
    .rdata_o (item_rdata)
  );

  gwd_ram #(.WIDTH(GSUM_W), .DEPTH(MAX_GROUPS)) u_group_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (gwdata),
    .raddr_i (grp_raddr),
    .rdata_o (grp_rdata)
  );

  // result path
  assign gidx = grp_q[GIW-1:0] - GIW'(1);
  assign gsum_rd = gvalid_q[gidx] ? grp_rdata : '0;

  assign areq.start = arith_start;
  assign areq.vsum = gsum_rd[GSUM_W-1:WSUM_W];
  assign areq.wsum = gsum_rd[WSUM_W-1:0];
  assign areq.weight = wgt_q;

  gwd_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (areq),
    .rsp_o  (arsp)
  );

  assign mul_p = ((state_q == S_MUL_LO) ? d_q[31:0] : d_q[63:32]) * arsp.scale;

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD_GRP) begin
      val_q <= item_rdata[31:0];
      wgt_q <= item_rdata[63:32];
      grp_q <= item_rdata[ITEM_W-1:64];
      status_q <= (item_rdata[ITEM_W-1:64] == 8'd0) ? ST_BAD_GROUP : ST_OK;
    end
    if (state_q == S_CHECK && status_q == ST_OK && gsum_rd[WSUM_W-1:0] == '0) begin
      status_q <= ST_ZERO_WSUM;
    end
    if (state_q == S_DIV && arsp.done) begin
      d_q <= {{32{val_q[31]}}, val_q} - arsp.mean;
    end
    if (state_q == S_MUL_LO) begin
      prod_q <= mul_p;
    end
    if (state_q == S_MUL_HI) begin
      r_q <= 64'(prod_q) + {mul_p[31:0], 32'b0};
    end
  end

  assign res_full = (mode_q == MODE_SQRT_W) ? 64'($signed(r_q) >>> 16) : d_q;
  assign sat = !((&res_full[63:31]) || !(|res_full[63:31]));
  assign res_clamp = sat ? (res_full[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : res_full[31:0];

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      ov_pos_q <= 6'(k_q);
      ov_drop_q <= ovf_q;
      ov_end_q <= last_res;
      if (status_q != ST_OK) begin
        ov_value_q <= '0;
        ov_status_q <= status_q;
      end else begin
        ov_value_q <= res_clamp;
        ov_status_q <= sat ? ST_SATURATED : ST_OK;
      end
    end
  end

  assign in_i.ready = in_ready;
  assign out_o.valid = ov_q;
  assign out_o.out_value = ov_value_q;
  assign out_o.position = ov_pos_q;
  assign out_o.status = ov_status_q;
  assign out_o.dropped = ov_drop_q;
  assign out_o.end_of_run = ov_end_q;

  count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ITEMS)) else $error("item count past capacity");
  write_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(state_q) == S_LOAD) else $error("group write outside load");
  batch_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_go && last_res |=> cnt_q == '0 && gvalid_q == '0)
    else $error("batch state not cleared");
  start_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_start |=> state_q == S_DIV) else $error("divider started out of sequence");

endmodule

>>> sv/gwd_ram.sv
module gwd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> sv/gwd_arith.sv
module gwd_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gwd_pkg::arith_req_t req_i,
  output gwd_pkg::arith_rsp_t rsp_o
);
  import gwd_pkg::*;

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [6:0]              cnt_q, cnt_d;
  logic                    neg_q, neg_d;
  logic [DIV_STEPS-1:0]    dvd_q, dvd_d;
  logic [WSUM_W-1:0]       dvs_q, dvs_d;
  logic [WSUM_W-1:0]       rem_q, rem_d;
  logic [63:0]             quo_q, quo_d;
  logic [47:0]             rad_q, rad_d;
  logic [26:0]             srem_q, srem_d;
  logic [SCALE_W-1:0]      root_q, root_d;

  logic [VSUM_W-1:0]       mag;
  logic [WSUM_W:0]         r2;
  logic [26:0]             s2;
  logic [26:0]             trial;

  assign mag = req_i.vsum[VSUM_W-1] ? VSUM_W'(-req_i.vsum) : VSUM_W'(req_i.vsum);
  assign r2 = {rem_q, dvd_q[DIV_STEPS-1]};
  assign s2 = {srem_q[24:0], rad_q[47:46]};
  assign trial = {1'b0, root_q, 2'b01};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    neg_d = neg_q;
    dvd_d = dvd_q;
    dvs_d = dvs_q;
    rem_d = rem_q;
    quo_d = quo_q;
    rad_d = rad_q;
    srem_d = srem_q;
    root_d = root_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = 7'(DIV_STEPS);
      neg_d = req_i.vsum[VSUM_W-1];
      dvd_d = {mag, 16'b0};
      dvs_d = req_i.wsum;
      rem_d = '0;
      quo_d = '0;
      rad_d = {req_i.weight, 16'b0};
      srem_d = '0;
      root_d = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIV_STEPS-2:0], 1'b0};
      if (r2 >= {1'b0, dvs_q}) begin
        rem_d = WSUM_W'(r2 - {1'b0, dvs_q});
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = r2[WSUM_W-1:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      if (cnt_q > 7'(DIV_STEPS - SQRT_STEPS)) begin
        rad_d = {rad_q[45:0], 2'b00};
        if (s2 >= trial) begin
          srem_d = s2 - trial;
          root_d = {root_q[SCALE_W-2:0], 1'b1};
        end else begin
          srem_d = s2;
          root_d = {root_q[SCALE_W-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    rad_q <= rad_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.mean = neg_q ? -quo_q : quo_q;
  assign rsp_o.scale = root_q;

  done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider finished without running");
  start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");
  count_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q == 7'd1 && !req_i.start |=> done_q && !busy_q)
    else $error("divider did not finish");

endmodule

>>> dv/gwd_checker.sv
`timescale 1ns / 1ps

module gwd_checker #(
  parameter int MAX_ITEMS = 64,
  parameter int MAX_GROUPS = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gwd_in_if                           in_m,
  gwd_out_if                          out_m,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gwd_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          result_count_o
);
  import gwd_pkg::*;

  typedef struct {
    logic signed [31:0] value;
    logic [5:0]         pos;
    status_e            st;
    logic               dropped;
    logic               eor;
  } demean_t;

  demean_t            demean_q[$];
  logic [1:0]         mode_q;
  logic [6:0]         gcount_q;
  longint             item_val[MAX_ITEMS];
  logic [31:0]        item_wt[MAX_ITEMS];
  int                 item_grp[MAX_ITEMS];
  longint             grp_vsum[MAX_GROUPS+1];
  logic [63:0]        grp_wsum[MAX_GROUPS+1];
  int                 loaded;
  logic               ovf_seen;

  assign pending_o = demean_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("ERROR at %0t: %s got %0h want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 46;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint group_mean(input longint s, input logic [63:0] w);
    logic [127:0] num;
    logic [127:0] q;
    logic [63:0]  mag;
    mag = (s < 0) ? 64'(-s) : 64'(s);
    num = {64'd0, mag} << 16;
    q = num / {64'd0, w};
    return (s < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  task automatic load_item(input logic [7:0] g, input logic signed [31:0] smp,
                           input logic [31:0] w, input logic lst);
    logic        ok;
    logic [63:0] we;
    logic [63:0] mag;
    logic [63:0] p;
    longint      v;
    longint      term;
    longint      mean;
    longint      d;
    longint      r;
    demean_t     e;
    v = longint'(smp);
    if (loaded < MAX_ITEMS) begin
      ok = g >= 1 && g <= gcount_q && g <= MAX_GROUPS;
      item_val[loaded] = v;
      item_wt[loaded] = w;
      item_grp[loaded] = ok ? int'(g) : 0;
      if (ok) begin
        we = (mode_q == MODE_PLAIN) ? 64'(ONE_Q16) : 64'(w);
        mag = (v < 0) ? 64'(-v) : 64'(v);
        p = we * mag;
        term = (v < 0) ? -longint'((p + 64'hffff) >> 16) : longint'(p >> 16);
        grp_vsum[g] += term;
        grp_wsum[g] += we;
      end
      loaded++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!lst) return;
    for (int k = 0; k < loaded; k++) begin
      e.st = ST_OK;
      r = 0;
      if (item_grp[k] == 0) begin
        e.st = ST_BAD_GROUP;
      end else if (grp_wsum[item_grp[k]] == 0) begin
        e.st = ST_ZERO_WSUM;
      end else begin
        mean = group_mean(grp_vsum[item_grp[k]], grp_wsum[item_grp[k]]);
        d = item_val[k] - mean;
        if (mode_q == MODE_SQRT_W)
          r = (d * longint'(sqrt_floor({32'd0, item_wt[k]} << 16))) >>> 16;
        else
          r = d;
        if (r > 64'sd2147483647) begin
          r = 64'sd2147483647;
          e.st = ST_SATURATED;
        end else if (r < -64'sd2147483648) begin
          r = -64'sd2147483648;
          e.st = ST_SATURATED;
        end
      end
      e.value = r[31:0];
      e.pos = k[5:0];
      e.dropped = ovf_seen;
      e.eor = (k == loaded - 1);
      demean_q.push_back(e);
    end
    for (int i = 0; i <= MAX_GROUPS; i++) begin
      grp_vsum[i] = 0;
      grp_wsum[i] = 0;
    end
    loaded = 0;
    ovf_seen = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    demean_t e;
    if (!rst_ni) begin
      mode_q = MODE_RESET;
      gcount_q = GROUP_COUNT_RESET;
      for (int i = 0; i <= MAX_GROUPS; i++) begin
        grp_vsum[i] = 0;
        grp_wsum[i] = 0;
      end
      loaded = 0;
      ovf_seen = 1'b0;
      demean_q.delete();
      fail_count_o = 0;
      result_count_o = 0;
    end else begin
      if (out_m.valid && out_m.ready) begin
        result_count_o++;
        if (demean_q.size() == 0) begin
          report("unexpected result, position", 64'(out_m.position), 64'hx);
        end else begin
          e = demean_q.pop_front();
          if (out_m.out_value !== e.value) report("out_value", 64'(out_m.out_value), 64'(e.value));
          if (out_m.position !== e.pos) report("position", 64'(out_m.position), 64'(e.pos));
          if (out_m.status !== e.st) report("status", 64'(out_m.status), 64'(e.st));
          if (out_m.dropped !== e.dropped) report("dropped", 64'(out_m.dropped), 64'(e.dropped));
          if (out_m.end_of_run !== e.eor) report("end_of_run", 64'(out_m.end_of_run), 64'(e.eor));
        end
      end
      if (in_m.valid && in_m.ready)
        load_item(in_m.group, in_m.sample, in_m.item_weight, in_m.last);
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_MODE) mode_q = pwdata[1:0];
        else if (paddr == ADDR_GROUP_COUNT) gcount_q = pwdata[6:0];
      end
    end
  end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gwd_pkg::*;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  int                 result_count;
  int                 item_count;
  int                 batch_count;
  logic               no_gaps;
  logic [6:0]         gcount;
  int                 stall_left;

  gwd_in_if  in_if ();
  gwd_out_if out_if ();

  grouped_weighted_demean u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if.sink),
    .out_o   (out_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gwd_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_m           (in_if),
    .out_m          (out_if),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("grouped_weighted_demean: mismatch");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_if.ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [1:0] m, input logic [6:0] gc);
    drain();
    reg_write(ADDR_MODE, {30'd0, m});
    reg_write(ADDR_GROUP_COUNT, {25'd0, gc});
    gcount = gc;
  endtask

  task automatic send_request(input logic [7:0] g, input logic [31:0] smp,
                              input logic [31:0] w, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.group <= g;
    in_if.sample <= smp;
    in_if.item_weight <= w;
    in_if.last <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    item_count++;
    if (lst) batch_count++;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(200000)) - 100000);
      default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'd0;
      2: return $urandom_range(8, 1) << 16;
      3: return $urandom_range(15);
      default: return $urandom_range(1) ? 32'hffff_ffff : $urandom_range(32'hffff);
    endcase
  endfunction

  function automatic logic [7:0] rand_group();
    int r;
    r = $urandom_range(99);
    if (r < 88) return $urandom_range(gcount, 1);
    if (r < 92) return 8'd0;
    return $urandom_range(255);
  endfunction

  task automatic rand_batch(input int len);
    for (int i = 0; i < len; i++)
      send_request(rand_group(), rand_sample(), rand_weight(), i == len - 1);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.group = '0;
    in_if.sample = '0;
    in_if.item_weight = '0;
    in_if.last = 1'b0;
    no_gaps = 1'b0;
    gcount = GROUP_COUNT_RESET;
    item_count = 0;
    batch_count = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: bad groups, extremes, zero weight sum, saturation
    set_regs(2'd1, 7'd64);
    send_request(8'd0, 32'h0001_0000, 32'h0001_0000, 1'b0);
    send_request(8'd255, 32'h0002_0000, 32'h0001_0000, 1'b0);
    send_request(8'd65, 32'h0002_0000, 32'h0001_0000, 1'b0);
    send_request(8'd3, 32'h1234_5678, 32'd0, 1'b0);
    send_request(8'd5, 32'h7fff_ffff, 32'd1, 1'b0);
    send_request(8'd5, 32'h8000_0000, 32'hffff_ffff, 1'b0);
    send_request(8'd64, 32'hffff_ffff, 32'h0003_0000, 1'b1);
    set_regs(2'd2, 7'd1);
    send_request(8'd1, 32'h7fff_ffff, 32'hffff_ffff, 1'b0);
    send_request(8'd1, 32'h8000_0000, 32'h0000_0001, 1'b0);
    send_request(8'd2, 32'h0000_0000, 32'h0001_0000, 1'b0);
    send_request(8'd1, 32'h0005_0000, 32'h0004_0000, 1'b1);
    set_regs(2'd3, 7'd2);
    send_request(8'd2, 32'h0010_0000, 32'h0002_0000, 1'b0);
    send_request(8'd2, 32'hfff0_0000, 32'h0001_0000, 1'b1);
    set_regs(2'd0, 7'd4);
    send_request(8'd4, 32'h8000_0000, 32'd0, 1'b0);
    send_request(8'd4, 32'h7fff_ffff, 32'd0, 1'b1);
    // capacity overflow with the last two requests dropped
    rand_batch(66);

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      set_regs(2'($urandom_range(3)), (ph == 0) ? 7'd1 : (ph == 1) ? 7'd64 :
               7'($urandom_range(64, 1)));
      no_gaps = (ph % 3 == 2);
      for (int b = 0; b < 6; b++) begin
        if (b == 3) begin
          drain();
        end
        rand_batch($urandom_range(12, 1));
      end
      if (ph == 5) rand_batch($urandom_range(70, 64));
    end
    drain();
    set_regs(2'd0, 7'd64);
    rand_batch(8);

    drain();
    repeat (30) @(posedge clk_i);
    $display("covered %0d requests in %0d batches, %0d results checked",
             item_count, batch_count, result_count);
    if (fail_count == 0) begin
      $display("grouped_weighted_demean: match");
    end else begin
      $display("grouped_weighted_demean: mismatch");
    end
    $finish;
  end

endmodule
